// ----- design/blpi_pkg.sv -----
`timescale 1ns / 1ps

package blpi_pkg;

    // Default sizing of the list.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 64;

    // Fixed widths of the channel fields.
    localparam int REQ_W     = 3;
    localparam int POS_W     = 5;
    localparam int ENTRY_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } blpi_cmd_t;

endpackage

// ----- design/blpi_ifs.sv -----
`timescale 1ns / 1ps

interface blpi_req_if;
    import blpi_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entry_data;

    modport source (output valid, output req_type, output position, output entry_data,
                    input ready);
    modport sink   (input valid, input req_type, input position, input entry_data,
                    output ready);
endinterface

interface blpi_rsp_if;
    import blpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 front_valid;
    logic [ENTRY_W-1:0]   front_data;

    modport source (output valid, output status, output entry_count, output front_valid,
                    output front_data, input ready);
    modport sink   (input valid, input status, input entry_count, input front_valid,
                    input front_data, output ready);
endinterface

// ----- design/blpi_ctrl.sv -----
`timescale 1ns / 1ps

module blpi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output blpi_pkg::blpi_cmd_t cmd
);
    import blpi_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // The result register is free when empty or when its word leaves this cycle.
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        cmd.capture    = in_valid && (state_reg == S_IDLE);
        cmd.commit     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/blpi_dp.sv -----
`timescale 1ns / 1ps

module blpi_dp #(
    parameter int CAPACITY   = blpi_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = blpi_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  blpi_pkg::blpi_cmd_t             cmd,
    input  logic [blpi_pkg::REQ_W-1:0]      req_type,
    input  logic [blpi_pkg::POS_W-1:0]      position,
    input  logic [blpi_pkg::ENTRY_W-1:0]    entry_data,
    output logic [blpi_pkg::STATUS_W-1:0]   status,
    output logic [blpi_pkg::CNT_OUT_W-1:0]  entry_count,
    output logic                            front_valid,
    output logic [blpi_pkg::ENTRY_W-1:0]    front_data
);
    import blpi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    // Wide enough to compare a position against count + 1 without overflow.
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Request held from capture until commit.
    logic [REQ_W-1:0]      req_type_reg;
    logic [POS_W-1:0]      position_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    // Row of cells with the front record in cell 0.
    logic [DATA_WIDTH-1:0] cells_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic [STATUS_W-1:0]   status_reg;
    logic [CNT_OUT_W-1:0]  entry_count_reg;
    logic                  front_valid_reg;
    logic [ENTRY_W-1:0]    front_data_reg;

    status_t               st;
    logic                  add_en;
    logic                  pos_ok;
    logic                  full;
    logic [CW-1:0]         idx;

    always_comb
    begin
        cells_next = cells_reg;
        count_next = count_reg;
        st         = ST_OK;
        add_en     = 1'b0;
        pos_ok     = 1'b1;
        idx        = '0;
        full       = (count_reg == CW'(CAPACITY));
        unique case (req_type_reg)
            REQ_PUSH_FRONT:
            begin
                add_en = 1'b1;
            end
            REQ_PUSH_BACK:
            begin
                add_en = 1'b1;
                idx    = count_reg;
            end
            REQ_INSERT:
            begin
                add_en = 1'b1;
                pos_ok = (position_reg != '0) &&
                         (PW'(position_reg) <= (PW'(count_reg) + PW'(1)));
                idx    = CW'(PW'(position_reg) - PW'(1));
            end
            REQ_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        cells_next[k] = cells_reg[(k + 1 < CAPACITY) ? k + 1 : k];
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                st = ST_RANGE;
            end
        endcase

        // A full list is reported before a bad position.
        if (add_en)
        begin
            if (full)
            begin
                st = ST_FULL;
            end
            else if (!pos_ok)
            begin
                st = ST_RANGE;
            end
            else
            begin
                for (int k = 0; k < CAPACITY; k++)
                begin
                    if (CW'(k) > idx)
                    begin
                        cells_next[k] = cells_reg[(k > 0) ? k - 1 : 0];
                    end
                    else if (CW'(k) == idx)
                    begin
                        cells_next[k] = data_reg;
                    end
                end
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            position_reg <= position;
            data_reg     <= entry_data[DATA_WIDTH-1:0];
        end
        if (cmd.commit)
        begin
            cells_reg       <= cells_next;
            status_reg      <= st;
            entry_count_reg <= CNT_OUT_W'(count_next);
            front_valid_reg <= (count_next != '0);
            front_data_reg  <= (count_next != '0) ? ENTRY_W'(cells_next[0]) : '0;
        end
    end

    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign front_valid = front_valid_reg;
    assign front_data  = front_data_reg;

endmodule

// ----- design/bounded_list_with_positional_insert_unit.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY records with positional insert.
// The req channel carries one request word: req_type (push front, push back,
// pop front, pop back, insert), a 1-based position used only by insert, and
// the record in entry_data, of which the low DATA_WIDTH bits are kept.
// The rsp channel returns exactly one word per request, in order: a status
// (success, full, out of range, empty), the record count afterwards, and the
// front record with its valid flag, zero when the list is empty.
// A request is taken into a holding register at the accepting edge; once the
// result register is free, the commit edge performs the whole shift of the cell
// row and loads the result register, which presents the response word.
// The controller works on one request at a time and takes no new request until
// the last one has been committed to the result register.
// The result register decouples the two channels: the next request is accepted
// while a response still waits, and if rsp stalls, that request is held until
// the result register frees up; nothing is dropped or repeated.
// Reset empties the list and clears all handshake state at once; record cells
// hold undefined data until written, and no clearing pass is needed.
module bounded_list_with_positional_insert_unit #(
    parameter int CAPACITY   = blpi_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = blpi_pkg::DATA_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    blpi_req_if.sink   req,
    blpi_rsp_if.source rsp
);
    import blpi_pkg::*;

    blpi_cmd_t cmd;

    // Controller: sequences capture and commit, owns the handshakes.
    blpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: the cell row, the count and the result register.
    blpi_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req.req_type),
        .position    (req.position),
        .entry_data  (req.entry_data),
        .status      (rsp.status),
        .entry_count (rsp.entry_count),
        .front_valid (rsp.front_valid),
        .front_data  (rsp.front_data)
    );

    // A full list always has a front record.
    a_full_has_front: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> rsp.front_valid)
        else $error("full status reported without a front record");

    // An empty pop leaves an empty list with zero front data.
    a_empty_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_EMPTY) |-> !rsp.front_valid && (rsp.front_data == '0))
        else $error("empty status reported with a front record");

    // The controller is busy for the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while previous one in work");

    // A committed request always presents its response next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit without response word");

endmodule
